[rtl/histogram_top_k_report_assert.svh]
// Assertion macros used by the histogram checker.
// Each macro expects clk_i and rst_ni to be visible where it is used.
`ifndef HISTOGRAM_TOP_K_REPORT_ASSERT_SVH
`define HISTOGRAM_TOP_K_REPORT_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define HTK_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define HTK_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/htk_pkg.sv]
package htk_pkg;

  // Fixed field widths of the command and result transfers.
  localparam int ValueW    = 7;
  localparam int OutCountW = 16;

  // Reset value of the highest accepted value register.
  localparam logic [ValueW-1:0] HvReset = 7'd45;

  // Command modes.
  localparam logic ModeRecord = 1'b0;
  localparam logic ModeReport = 1'b1;

  // Result status codes.
  localparam logic StatusRanked   = 1'b0;
  localparam logic StatusRejected = 1'b1;

  typedef struct packed {
    logic              mode;
    logic [ValueW-1:0] value;
  } cmd_t;

  typedef struct packed {
    logic [ValueW-1:0]    ranked_value;
    logic [OutCountW-1:0] ranked_count;
    logic                 status;
    logic                 last;
  } result_t;

  // Controls from the sequencer to the running-maximum unit.
  typedef struct packed {
    logic clear;
    logic cmp_en;
  } max_ctrl_t;

  typedef enum logic [5:0] {
    StIdle  = 6'b000001,
    StRecWr = 6'b000010,
    StScan  = 6'b000100,
    StDrain = 6'b001000,
    StEmit  = 6'b010000,
    StSpare = 6'b100000
  } state_e;

endpackage

[rtl/htk_bin_mem.sv]
module htk_bin_mem #(
  parameter int NUM_BINS    = 64,
  parameter int COUNT_WIDTH = 16,
  parameter int IDX_W       = 6
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   re_i,
  input  logic [IDX_W-1:0]       raddr_i,
  output logic [COUNT_WIDTH-1:0] rdata_o,
  input  logic                   we_i,
  input  logic [IDX_W-1:0]       waddr_i,
  input  logic [COUNT_WIDTH-1:0] wdata_i
);

  logic [COUNT_WIDTH-1:0] mem_q [NUM_BINS];
  logic [NUM_BINS-1:0]    valid_q;
  logic [COUNT_WIDTH-1:0] rdata_q;

  // Per-entry valid bits: an entry never written since reset reads as zero.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (we_i) begin
      valid_q[waddr_i] <= 1'b1;
    end
  end

  // Count storage with one write port and one registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= valid_q[raddr_i] ? mem_q[raddr_i] : '0;
    end
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/htk_max_unit.sv]
module htk_max_unit import htk_pkg::*; #(
  parameter int COUNT_WIDTH = 16,
  parameter int IDX_W       = 6
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  max_ctrl_t              ctrl_i,
  input  logic [COUNT_WIDTH-1:0] data_i,
  input  logic [IDX_W-1:0]       idx_i,
  output logic [COUNT_WIDTH-1:0] best_o,
  output logic [IDX_W-1:0]       top_o
);

  logic [COUNT_WIDTH-1:0] best_q, best_d;
  logic [IDX_W-1:0]       top_q, top_d;

  // Only a strictly greater count replaces the holder, so ties keep the first bin.
  always_comb begin
    best_d = best_q;
    top_d  = top_q;
    if (ctrl_i.clear) begin
      best_d = '0;
      top_d  = '0;
    end else if (ctrl_i.cmp_en && (data_i > best_q)) begin
      best_d = data_i;
      top_d  = idx_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      best_q <= '0;
      top_q  <= '0;
    end else begin
      best_q <= best_d;
      top_q  <= top_d;
    end
  end

  assign best_o = best_q;
  assign top_o  = top_q;

endmodule

[rtl/histogram_top_k_report.sv]
// Histogram with top-k report. A command transfer is taken when start is high
// and busy is low. A record command whose value is in range does one memory
// read and one write-back and gives no result; an out-of-range record gives
// one rejected result in the next cycle and does not raise busy. A report
// makes TOP_K passes, where L is highest_value clamped to 1..NUM_BINS: every
// pass reads the L bins one per cycle through the single read port of the
// count memory, then a drain state does the last compare and an emit state
// outputs and clears the winning bin. Each result is shown for exactly one cycle
// with result_valid_o high and cannot be held off, so the receiver must take it then.
// Counts clear at reset through per-bin valid bits; no clearing pass is needed.
module histogram_top_k_report import htk_pkg::*; #(
  parameter int NUM_BINS    = 64,
  parameter int TOP_K       = 6,
  parameter int COUNT_WIDTH = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  cmd_t              cmd_i,
  input  logic              cfg_we_i,
  input  logic [ValueW-1:0] cfg_wdata_i,
  output logic              result_valid_o,
  output result_t           result_o
);

  localparam int IdxW = $clog2(NUM_BINS);
  localparam int LimW = $clog2(NUM_BINS + 1);
  localparam int KW   = (TOP_K > 1) ? $clog2(TOP_K) : 1;

  state_e                 state_q, state_d;
  logic [ValueW-1:0]      hv_q;
  logic [IdxW-1:0]        j_q, j_d;
  logic [KW-1:0]          k_q, k_d;
  logic [IdxW-1:0]        addr_q, addr_d;
  logic                   cmp_vld_q, cmp_vld_d;
  logic [IdxW-1:0]        cmp_idx_q;
  logic                   res_vld_q, res_vld_d;
  result_t                res_q, res_d;

  logic [LimW-1:0]        lim;
  logic                   last_j;
  logic                   reject;
  logic                   accept;
  logic                   mem_re, mem_we;
  logic [IdxW-1:0]        mem_raddr, mem_waddr;
  logic [COUNT_WIDTH-1:0] mem_wdata, mem_rdata;
  max_ctrl_t              max_ctrl;
  logic [COUNT_WIDTH-1:0] best;
  logic [IdxW-1:0]        top;
  logic [OutCountW-1:0]   best_sat;

  // Clamp the register to the range 1 to the number of bins actually kept.
  always_comb begin
    if (hv_q == '0) begin
      lim = LimW'(1);
    end else if (32'(hv_q) > NUM_BINS) begin
      lim = LimW'(NUM_BINS);
    end else begin
      lim = LimW'(hv_q);
    end
  end

  assign last_j = (32'(j_q) == (32'(lim) - 32'd1));
  assign reject = (cmd_i.value == '0) || (32'(cmd_i.value) > 32'(lim));
  assign accept = start && !busy;
  assign busy   = (state_q != StIdle);

  // Counts wider than the result field saturate on output.
  assign best_sat = (32'(best) > 32'd65535) ? '1 : OutCountW'(best);

  // Sequencer for record read-modify-write, rejected records and the report passes.
  always_comb begin
    state_d      = state_q;
    j_d          = j_q;
    k_d          = k_q;
    addr_d       = addr_q;
    res_vld_d    = 1'b0;
    res_d        = res_q;
    mem_re       = 1'b0;
    mem_raddr    = j_q;
    mem_we       = 1'b0;
    mem_waddr    = addr_q;
    mem_wdata    = '0;
    max_ctrl     = '0;
    max_ctrl.cmp_en = cmp_vld_q;
    cmp_vld_d    = (state_q == StScan);
    case (state_q)
      StIdle: begin
        if (accept) begin
          if (cmd_i.mode == ModeReport) begin
            state_d        = StScan;
            j_d            = '0;
            k_d            = '0;
            max_ctrl.clear = 1'b1;
          end else if (reject) begin
            res_vld_d          = 1'b1;
            res_d.ranked_value = cmd_i.value;
            res_d.ranked_count = '0;
            res_d.status       = StatusRejected;
            res_d.last         = 1'b1;
          end else begin
            mem_re    = 1'b1;
            mem_raddr = IdxW'(cmd_i.value - 7'd1);
            addr_d    = IdxW'(cmd_i.value - 7'd1);
            state_d   = StRecWr;
          end
        end
      end
      StRecWr: begin
        mem_we    = 1'b1;
        mem_waddr = addr_q;
        mem_wdata = (mem_rdata == '1) ? mem_rdata : mem_rdata + COUNT_WIDTH'(1);
        state_d   = StIdle;
      end
      StScan: begin
        mem_re    = 1'b1;
        mem_raddr = j_q;
        if (last_j) begin
          state_d = StDrain;
        end else begin
          j_d = j_q + IdxW'(1);
        end
      end
      StDrain: begin
        state_d = StEmit;
      end
      StEmit: begin
        res_vld_d          = 1'b1;
        res_d.ranked_value = ValueW'(32'(top) + 32'd1);
        res_d.ranked_count = best_sat;
        res_d.status       = StatusRanked;
        res_d.last         = (k_q == KW'(TOP_K - 1));
        mem_we             = 1'b1;
        mem_waddr          = top;
        mem_wdata          = '0;
        max_ctrl.clear     = 1'b1;
        if (k_q == KW'(TOP_K - 1)) begin
          state_d = StIdle;
        end else begin
          k_d     = k_q + KW'(1);
          j_d     = '0;
          state_d = StScan;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= StIdle;
      hv_q      <= HvReset;
      j_q       <= '0;
      k_q       <= '0;
      cmp_vld_q <= 1'b0;
      res_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      j_q       <= j_d;
      k_q       <= k_d;
      cmp_vld_q <= cmp_vld_d;
      res_vld_q <= res_vld_d;
      if (cfg_we_i) begin
        hv_q <= cfg_wdata_i;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    addr_q    <= addr_d;
    cmp_idx_q <= j_q;
    res_q     <= res_d;
  end

  htk_bin_mem #(
    .NUM_BINS   (NUM_BINS),
    .COUNT_WIDTH(COUNT_WIDTH),
    .IDX_W      (IdxW)
  ) u_bin_mem (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .re_i   (mem_re),
    .raddr_i(mem_raddr),
    .rdata_o(mem_rdata),
    .we_i   (mem_we),
    .waddr_i(mem_waddr),
    .wdata_i(mem_wdata)
  );

  htk_max_unit #(
    .COUNT_WIDTH(COUNT_WIDTH),
    .IDX_W      (IdxW)
  ) u_max_unit (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .ctrl_i(max_ctrl),
    .data_i(mem_rdata),
    .idx_i (cmp_idx_q),
    .best_o(best),
    .top_o (top)
  );

  assign result_valid_o = res_vld_q;
  assign result_o       = res_q;

endmodule

[rtl/htk_checker.sv]
`include "histogram_top_k_report_assert.svh"

module htk_checker import htk_pkg::*; (
  input logic    clk_i,
  input logic    rst_ni,
  input logic    start,
  input logic    busy,
  input cmd_t    cmd_i,
  input logic    result_valid_o,
  input result_t result_o
);

  // A report transfer keeps the block busy while it scans.
  `HTK_ASSERT_NEXT(a_report_busy, start && !busy && (cmd_i.mode == ModeReport), busy, "report did not raise busy")

  // After a ranked result that is not the last, the report is still running.
  `HTK_ASSERT_NEXT(a_more_ranks, result_valid_o && (result_o.status == StatusRanked) && !result_o.last, busy, "report ended early")

  // A rejected record yields a single result with a zero count.
  `HTK_ASSERT_SAME(a_reject_form, result_valid_o && (result_o.status == StatusRejected), result_o.last && (result_o.ranked_count == '0), "malformed rejected result")

  // Once idle, any result shown must close its command.
  `HTK_ASSERT_SAME(a_idle_last, result_valid_o && !busy, result_o.last, "non-final result while idle")

endmodule

bind histogram_top_k_report htk_checker u_htk_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .start         (start),
  .busy          (busy),
  .cmd_i         (cmd_i),
  .result_valid_o(result_valid_o),
  .result_o      (result_o)
);

[tb/tb_histogram_top_k_report.sv]
`timescale 1ns / 1ps

module tb_histogram_top_k_report;
  import htk_pkg::*;

  localparam int NUM_BINS    = 64;
  localparam int TOP_K       = 6;
  localparam int COUNT_WIDTH = 16;
  localparam int CycleLimit  = 400_000;

  // Predicts the histogram contents and the ranked results that each command causes.
  class top_k_predictor;
    logic [COUNT_WIDTH-1:0] bin_count [NUM_BINS];
    logic [ValueW-1:0]      highest;
    result_t                expected_results [$];
    int unsigned            errors;

    function new();
      foreach (bin_count[i]) bin_count[i] = '0;
      highest = HvReset;
      errors  = 0;
    endfunction

    // The register is clamped to the range of existing bins.
    function int unsigned limit();
      if (highest == 0) return 1;
      if (highest > NUM_BINS) return NUM_BINS;
      return highest;
    endfunction

    function void set_highest(logic [ValueW-1:0] v);
      highest = v;
    endfunction

    function int pending();
      return expected_results.size();
    endfunction

    // Called for every accepted command transfer.
    function void note_command(cmd_t c);
      int unsigned lim;
      int unsigned best;
      int unsigned top;
      result_t     r;
      lim = limit();
      if (c.mode == ModeRecord) begin
        if (c.value == 0 || c.value > lim) begin
          r.ranked_value = c.value;
          r.ranked_count = '0;
          r.status       = StatusRejected;
          r.last         = 1'b1;
          expected_results.push_back(r);
        end else if (bin_count[c.value-1] != '1) begin
          bin_count[c.value-1] = bin_count[c.value-1] + 1'b1;
        end
      end else begin
        // Each pass takes the first strictly greatest bin and clears it.
        for (int k = 0; k < TOP_K; k++) begin
          best = 0;
          top  = 0;
          for (int unsigned j = 0; j < lim; j++) begin
            if (bin_count[j] > best) begin
              best = bin_count[j];
              top  = j;
            end
          end
          r.ranked_value = ValueW'(top + 1);
          // Counts wider than the result field saturate.
          r.ranked_count = (bin_count[top] > 65535) ? '1 : OutCountW'(bin_count[top]);
          r.status       = StatusRanked;
          r.last         = (k == TOP_K - 1);
          expected_results.push_back(r);
          bin_count[top] = '0;
        end
      end
    endfunction

    function void compare_field(string field, int unsigned exp_v, int unsigned act_v);
      if (exp_v != act_v) begin
        errors++;
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, exp_v, act_v);
      end
    endfunction

    // Called for every result transfer; compares it with the oldest expectation.
    function void check_result(result_t r);
      result_t e;
      if (expected_results.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none, actual value %0d count %0d",
                 $time, r.ranked_value, r.ranked_count);
        return;
      end
      e = expected_results.pop_front();
      compare_field("ranked_value", e.ranked_value, r.ranked_value);
      compare_field("ranked_count", e.ranked_count, r.ranked_count);
      compare_field("status", e.status, r.status);
      compare_field("last", e.last, r.last);
    endfunction
  endclass

  logic              clk_i       = 1'b0;
  logic              rst_ni      = 1'b0;
  logic              start       = 1'b0;
  logic              busy;
  cmd_t              cmd_i       = '0;
  logic              cfg_we_i    = 1'b0;
  logic [ValueW-1:0] cfg_wdata_i = '0;
  logic              result_valid_o;
  result_t           result_o;

  int unsigned    cycle_count = 0;
  top_k_predictor board = new();

  histogram_top_k_report #(
    .NUM_BINS    (NUM_BINS),
    .TOP_K       (TOP_K),
    .COUNT_WIDTH (COUNT_WIDTH)
  ) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .cmd_i          (cmd_i),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .result_valid_o (result_valid_o),
    .result_o       (result_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
  end

  // Watch every edge: results first, since they belong to earlier commands.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (result_valid_o) board.check_result(result_o);
      if (cfg_we_i) board.set_highest(cfg_wdata_i);
      if (start && !busy) board.note_command(cmd_i);
    end
  end

  initial begin
    wait (cycle_count >= CycleLimit);
    $display("** histogram_top_k_report: FAILED **");
    $finish;
  end

  // Offers one command and holds it until the transfer; then idles at random.
  task automatic send_cmd(cmd_t c, int unsigned idle_pct);
    start <= 1'b1;
    cmd_i <= c;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    if ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(5, 1)) @(posedge clk_i);
    end
  endtask

  // Lets every expected result arrive and the block settle.
  task automatic wait_idle();
    start <= 1'b0;
    @(posedge clk_i);
    while (board.pending() != 0 || busy) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_limit(logic [ValueW-1:0] v);
    wait_idle();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  // Mostly in-range records, clustered on low values to create ties.
  task automatic random_items(int n, int unsigned idle_pct);
    int unsigned pick;
    int unsigned lim;
    cmd_t        c;
    for (int i = 0; i < n; i++) begin
      pick = $urandom_range(99);
      lim  = board.limit();
      c.mode  = ModeRecord;
      c.value = ValueW'($urandom_range(lim, 1));
      if (pick < 10) begin
        c.mode  = ModeReport;
        c.value = ValueW'($urandom);
      end else if (pick < 18) begin
        c.value = ($urandom_range(1) == 0) ? '0 : ValueW'($urandom_range(127, lim + 1));
      end else if (pick < 50) begin
        c.value = ValueW'($urandom_range((lim < 4) ? lim : 4, 1));
      end
      send_cmd(c, idle_pct);
    end
  endtask

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: an empty histogram, rejects at both ends, ties and the limit edge.
    send_cmd('{ModeReport, 7'd0}, 0);
    send_cmd('{ModeRecord, 7'd0}, 0);
    send_cmd('{ModeRecord, 7'd127}, 0);
    send_cmd('{ModeRecord, 7'd45}, 0);
    send_cmd('{ModeRecord, 7'd46}, 0);
    send_cmd('{ModeRecord, 7'd5}, 0);
    send_cmd('{ModeRecord, 7'd3}, 0);
    send_cmd('{ModeRecord, 7'd5}, 0);
    send_cmd('{ModeRecord, 7'd3}, 0);
    send_cmd('{ModeRecord, 7'd7}, 0);
    send_cmd('{ModeRecord, 7'd40}, 0);
    send_cmd('{ModeReport, 7'd127}, 0);

    // A zero register acts as one.
    write_limit(7'd0);
    send_cmd('{ModeRecord, 7'd1}, 0);
    send_cmd('{ModeRecord, 7'd2}, 0);
    send_cmd('{ModeReport, 7'd0}, 0);

    // Counts above a lowered limit survive and come back when it is raised.
    write_limit(7'd64);
    send_cmd('{ModeRecord, 7'd64}, 0);
    send_cmd('{ModeRecord, 7'd65}, 0);
    send_cmd('{ModeRecord, 7'd40}, 0);
    send_cmd('{ModeRecord, 7'd40}, 0);
    write_limit(7'd1);
    send_cmd('{ModeReport, 7'd0}, 0);
    write_limit(7'd127);
    send_cmd('{ModeReport, 7'd0}, 0);

    // Random phases with different limits and sender idling.
    write_limit(HvReset);
    random_items(40, 0);
    write_limit(7'd64);
    random_items(40, 67);
    write_limit(7'd127);
    random_items(40, 17);
    write_limit(ValueW'($urandom_range(63, 2)));
    random_items(40, $urandom_range(80));

    wait_idle();
    repeat (20) @(posedge clk_i);
    if (board.errors == 0 && board.pending() == 0) begin
      $display("** histogram_top_k_report: PASSED **");
    end else begin
      $display("** histogram_top_k_report: FAILED **");
    end
    $finish;
  end

endmodule

[filelist.f]
+incdir+rtl
rtl/htk_pkg.sv
rtl/htk_bin_mem.sv
rtl/htk_max_unit.sv
rtl/histogram_top_k_report.sv
rtl/htk_checker.sv
tb/tb_histogram_top_k_report.sv
